>>> rtl/lac_pkg.sv
`default_nettype none

package lac_pkg;

    localparam logic [31:0] BG_RESET = 32'hFF1F1F1F;
    localparam logic [7:0]  CH_MAX   = 8'hFF;

    typedef struct packed {
        logic [7:0] src_alpha;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [8:0] layer_opacity;
        logic       layer_visible;
        logic       first_layer;
        logic       last_layer;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALPHA,
        ST_PRODUCT,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic alpha_en;
        logic prod_en;
        logic write_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/lac_ctrl.sv
`default_nettype none

module lac_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lac_pkg::dp_status_t status,
    output lac_pkg::ctrl_cmd_t      cmd
);

    lac_pkg::ctrl_state_t state_reg;
    lac_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lac_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            lac_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = lac_pkg::ST_ALPHA;
                end
            end
            lac_pkg::ST_ALPHA: begin
                cmd.alpha_en = 1'b1;
                state_next   = lac_pkg::ST_PRODUCT;
            end
            lac_pkg::ST_PRODUCT: begin
                cmd.prod_en = 1'b1;
                state_next  = lac_pkg::ST_WRITE;
            end
            lac_pkg::ST_WRITE: begin
                // a top layer holds while the previous result is still waiting
                if (!status.last || status.out_free) begin
                    cmd.write_en = 1'b1;
                    state_next   = lac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/lac_datapath.sv
`default_nettype none

module lac_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire lac_pkg::in_item_t   s_data,
    input  wire lac_pkg::ctrl_cmd_t  cmd,
    output lac_pkg::dp_status_t      status,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lac_pkg::out_item_t       m_data
);

    // floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] est;
        logic [8:0]  q0;
        logic [16:0] rem;
        logic [8:0]  q;
        begin
            est = {1'b0, x} + {9'd0, x[15:8]};
            q0  = est[16:8];
            rem = {1'b0, x} - (({8'd0, q0} << 8) - {8'd0, q0});
            q   = (rem >= 17'd255) ? q0 + 9'd1 : q0;
            div255 = q[7:0];
        end
    endfunction

    lac_pkg::in_item_t item_reg;
    logic [31:0]       bg_reg;
    logic [31:0]       accum_reg;
    logic [7:0]        alpha_reg;
    logic              blend_reg;
    logic [15:0]       sum_reg [3];
    lac_pkg::out_item_t out_reg;
    logic              out_valid_reg;

    logic [16:0] alpha_prod;
    logic [7:0]  alpha_sat;
    logic [7:0]  inv_alpha;
    logic [7:0]  dst_ch [3];
    logic [7:0]  src_ch [3];
    logic [15:0] sum_next [3];
    logic [7:0]  new_alpha;
    logic [31:0] accum_next;

    assign alpha_prod = {9'd0, item_reg.src_alpha} * {8'd0, item_reg.layer_opacity};
    assign alpha_sat  = (alpha_prod[16:8] > {1'b0, lac_pkg::CH_MAX}) ? lac_pkg::CH_MAX
                                                                      : alpha_prod[15:8];
    assign inv_alpha  = lac_pkg::CH_MAX - alpha_reg;

    assign dst_ch[0] = accum_reg[23:16];
    assign dst_ch[1] = accum_reg[15:8];
    assign dst_ch[2] = accum_reg[7:0];
    assign src_ch[0] = item_reg.src_red;
    assign src_ch[1] = item_reg.src_green;
    assign src_ch[2] = item_reg.src_blue;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = ({8'd0, dst_ch[i]} * {8'd0, inv_alpha})
                        + ({8'd0, src_ch[i]} * {8'd0, alpha_reg});
        end
    end

    assign new_alpha  = (alpha_reg > accum_reg[31:24]) ? alpha_reg : accum_reg[31:24];
    assign accum_next = blend_reg ? {new_alpha, div255(sum_reg[0]), div255(sum_reg[1]),
                                     div255(sum_reg[2])}
                                  : accum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg        <= lac_pkg::BG_RESET;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bg_reg <= cfg_wr_data;
            end
            if (cmd.load && s_data.first_layer) begin
                accum_reg <= bg_reg;
            end else if (cmd.write_en) begin
                accum_reg <= accum_next;
            end
            if (cmd.write_en && item_reg.last_layer) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.alpha_en) begin
            alpha_reg <= alpha_sat;
            blend_reg <= item_reg.layer_visible && (alpha_sat != 8'd0);
        end
        if (cmd.prod_en) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= sum_next[i];
            end
        end
        if (cmd.write_en && item_reg.last_layer) begin
            out_reg <= accum_next;
        end
    end

    assign status.last     = item_reg.last_layer;
    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;

endmodule

`default_nettype wire

>>> rtl/layer_alpha_compositor_unit.sv
`default_nettype none

// Source-over compositor for one pixel position across a stack of layers.
// Send the layers bottom to top, marking the bottom with first_layer (loads
// the background colour) and the top with last_layer (emits the pixel).
// Each layer goes through the controller sequence: opacity multiply,
// per-channel products, then divide by 255 and accumulator write-back. A top
// layer waits in the write-back step while the previous pixel is still held
// on the result side. The user writes the background colour through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
module layer_alpha_compositor_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lac_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lac_pkg::out_item_t      m_data
);

    lac_pkg::ctrl_cmd_t  cmd;
    lac_pkg::dp_status_t status;

    lac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lac_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // a top layer never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.write_en && status.last) |-> status.out_free)
        else $error("result overwritten while pending");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // a result appears only after a write-back step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.write_en))
        else $error("result without write-back");

endmodule

`default_nettype wire

>>> bench/lac_pixel_checker.sv
`timescale 1ns / 100ps

module lac_pixel_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lac_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lac_pkg::out_item_t  m_data,
    output int                  fail_count,
    output int                  pending
);

    logic [31:0]        bg_colour;
    lac_pkg::out_item_t accum;
    lac_pkg::out_item_t want;
    lac_pkg::out_item_t expected_pixels [$];
    logic [16:0]        alpha_prod;
    logic [7:0]         eff_alpha;

    function automatic logic [7:0] blend_channel(logic [7:0] dst, logic [7:0] src,
                                                 logic [7:0] a);
        logic [16:0] sum;
        sum = 17'(dst) * 17'(lac_pkg::CH_MAX - a) + 17'(src) * 17'(a);
        return 8'(sum / 17'd255);
    endfunction

    task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            bg_colour = lac_pkg::BG_RESET;
            accum = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                bg_colour = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                if (s_data.first_layer) begin
                    accum = bg_colour;
                end
                alpha_prod = 17'(s_data.src_alpha) * 17'(s_data.layer_opacity);
                eff_alpha = (alpha_prod[16:8] > 9'd255) ? lac_pkg::CH_MAX : alpha_prod[15:8];
                if (s_data.layer_visible && eff_alpha != 8'd0) begin
                    accum.out_red   = blend_channel(accum.out_red, s_data.src_red, eff_alpha);
                    accum.out_green = blend_channel(accum.out_green, s_data.src_green,
                                                    eff_alpha);
                    accum.out_blue  = blend_channel(accum.out_blue, s_data.src_blue, eff_alpha);
                    if (eff_alpha > accum.out_alpha) begin
                        accum.out_alpha = eff_alpha;
                    end
                end
                if (s_data.last_layer) begin
                    expected_pixels.push_back(accum);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: pixel %h with none expected", $time, m_data);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("alpha", want.out_alpha, m_data.out_alpha);
                    check_field("red", want.out_red, m_data.out_red);
                    check_field("green", want.out_green, m_data.out_green);
                    check_field("blue", want.out_blue, m_data.out_blue);
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

>>> bench/layer_alpha_compositor_unit_tb.sv
`timescale 1ns / 100ps

module layer_alpha_compositor_unit_tb;

    localparam int PHASE_LAYERS  = 150;
    localparam int SETTLE_CYCLES = 20;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    lac_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    lac_pkg::out_item_t m_data;
    int                 fail_count;
    int                 pending;
    bit                 calm;

    logic [31:0] bg_settings [4] = '{32'h00000000, 32'hFFFFFFFF, 32'h80402010, 32'h00FFFFFF};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    layer_alpha_compositor_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    lac_pixel_checker pixel_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    function automatic lac_pkg::in_item_t make_layer(logic [7:0] a, logic [7:0] r,
                                                     logic [7:0] g, logic [7:0] b,
                                                     logic [8:0] op, logic vis,
                                                     logic first, logic last);
        lac_pkg::in_item_t l;
        l.src_alpha     = a;
        l.src_red       = r;
        l.src_green     = g;
        l.src_blue      = b;
        l.layer_opacity = op;
        l.layer_visible = vis;
        l.first_layer   = first;
        l.last_layer    = last;
        return l;
    endfunction

    function automatic lac_pkg::in_item_t random_layer(logic first, logic last);
        logic [7:0] a;
        logic [8:0] op;
        case ($urandom_range(0, 7))
            0: a = 8'd0;
            1: a = 8'd255;
            default: a = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: op = 9'd0;
            1, 2: op = 9'd256;
            3: op = 9'($urandom_range(257, 511));
            default: op = 9'($urandom_range(0, 256));
        endcase
        return make_layer(a, 8'($urandom), 8'($urandom), 8'($urandom), op,
                          $urandom_range(0, 6) != 0, first, last);
    endfunction

    task automatic send_layer(lac_pkg::in_item_t l);
        bit took;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= l;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    // mostly whole stacks bottom to top, some stray layers with random markers
    task automatic send_random_layers(int count);
        int sent;
        int depth;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_layer(random_layer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                sent++;
            end else begin
                depth = $urandom_range(1, 6);
                for (int i = 0; i < depth; i++) begin
                    send_layer(random_layer(i == 0, i == depth - 1));
                end
                sent += depth;
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        calm = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // no bottom layer yet, then blending onto the previous pixel
        send_layer(make_layer(8'd255, 8'd255, 8'd0, 8'd128, 9'd256, 1'b1, 1'b0, 1'b1));
        send_layer(make_layer(8'd200, 8'd10, 8'd250, 8'd60, 9'd100, 1'b1, 1'b0, 1'b1));
        send_layer(make_layer(8'd255, 8'd0, 8'd255, 8'd1, 9'd256, 1'b1, 1'b1, 1'b1));
        // hidden, transparent and zero-opacity layers leave the background
        send_layer(make_layer(8'd255, 8'd99, 8'd99, 8'd99, 9'd256, 1'b0, 1'b1, 1'b1));
        send_layer(make_layer(8'd0, 8'd99, 8'd99, 8'd99, 9'd256, 1'b1, 1'b1, 1'b1));
        send_layer(make_layer(8'd255, 8'd99, 8'd99, 8'd99, 9'd0, 1'b1, 1'b1, 1'b1));
        send_layer(make_layer(8'd1, 8'd200, 8'd200, 8'd200, 9'd255, 1'b1, 1'b1, 1'b1));
        send_layer(make_layer(8'd1, 8'd200, 8'd200, 8'd200, 9'd256, 1'b1, 1'b1, 1'b1));
        // opacity above one, saturating
        send_layer(make_layer(8'd255, 8'd170, 8'd85, 8'd240, 9'd511, 1'b1, 1'b1, 1'b1));
        send_layer(make_layer(8'd171, 8'd15, 8'd240, 8'd51, 9'd300, 1'b1, 1'b1, 1'b1));
        send_layer(make_layer(8'd128, 8'd255, 8'd0, 8'd0, 9'd256, 1'b1, 1'b1, 1'b0));
        send_layer(make_layer(8'd64, 8'd0, 8'd255, 8'd0, 9'd128, 1'b1, 1'b0, 1'b0));
        send_layer(make_layer(8'd255, 8'd0, 8'd0, 8'd255, 9'd256, 1'b0, 1'b0, 1'b0));
        send_layer(make_layer(8'd90, 8'd0, 8'd0, 8'd255, 9'd511, 1'b1, 1'b0, 1'b1));
        send_layer(make_layer(8'd255, 8'd12, 8'd34, 8'd56, 9'd1, 1'b1, 1'b0, 1'b0));
        send_layer(make_layer(8'd77, 8'd1, 8'd2, 8'd3, 9'd384, 1'b1, 1'b0, 1'b1));
        send_layer(make_layer(8'd20, 8'd0, 8'd0, 8'd0, 9'd256, 1'b1, 1'b1, 1'b1));
        send_layer(make_layer(8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 1'b1, 1'b1, 1'b1));
        send_random_layers(PHASE_LAYERS);

        for (int p = 0; p < 6; p++) begin
            drain();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= (p < 4) ? bg_settings[p] : $urandom();
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            if (p == 5) begin
                calm = 1'b1;
            end
            send_random_layers(PHASE_LAYERS);
        end

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/lac_pkg.sv
rtl/lac_ctrl.sv
rtl/lac_datapath.sv
rtl/layer_alpha_compositor_unit.sv
bench/lac_pixel_checker.sv
bench/layer_alpha_compositor_unit_tb.sv
